>>> design/wbfs_pkg.sv
// shared types and constants of the width bounded fifo shelf
`timescale 1ns / 1ps
`default_nettype none
package wbfs_pkg;

	localparam int ID_W         = 16;
	localparam int WIDTH_W      = 16;
	localparam int CAP_W        = 16;
	localparam int MAX_BOOKS_DEF = 32;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_DUMP   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_CHECK,
		ST_ADD_EVICT,
		ST_REM_SCAN,
		ST_REM_SHIFT,
		ST_DUMP_START,
		ST_DUMP_OUT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [WIDTH_W-1:0] width;
	} entry_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic rd_head;
		logic evict;
		logic append;
		logic scan_rd;
		logic rem_sub;
		logic shift_wr;
		logic rem_done;
		logic dump_init;
		logic dump_rd;
		logic out_load_entry;
		logic out_load_empty;
	} cmd_t;

	typedef struct packed {
		logic too_wide;
		logic need_evict;
		logic count_zero;
		logic scan_more;
		logic rd_valid;
		logic id_match;
		logic off_one;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> design/wbfs_ctrl.sv
// sequencing state machine of the shelf
`timescale 1ns / 1ps
`default_nettype none
module wbfs_ctrl
	import wbfs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_mode,
	output logic            in_ready,
	input  wire sts_t       sts,
	output cmd_t            cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_mode)
						MODE_ADD:    state_d = ST_ADD_CHECK;
						MODE_REMOVE: state_d = ST_REM_SCAN;
						MODE_DUMP:   state_d = ST_DUMP_START;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_CHECK: begin
				if (sts.too_wide) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else if (sts.need_evict) begin
					cmd.rd_head = 1'b1;
					state_d     = ST_ADD_EVICT;
				end else begin
					cmd.append = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_ADD_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = ST_ADD_CHECK;
			end
			ST_REM_SCAN: begin
				cmd.scan_rd = sts.scan_more;
				if (sts.rd_valid && sts.id_match) begin
					cmd.rem_sub = 1'b1;
					state_d     = ST_REM_SHIFT;
				end else if (!sts.rd_valid && !sts.scan_more) begin
					state_d = ST_IDLE;
				end
			end
			ST_REM_SHIFT: begin
				cmd.scan_rd = sts.scan_more;
				if (sts.rd_valid) begin
					cmd.shift_wr = 1'b1;
				end else begin
					cmd.rem_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DUMP_START: begin
				if (sts.count_zero) begin
					if (sts.out_free) begin
						cmd.out_load_empty = 1'b1;
						state_d            = ST_IDLE;
					end
				end else begin
					cmd.dump_init = 1'b1;
					state_d       = ST_DUMP_OUT;
				end
			end
			ST_DUMP_OUT: begin
				if (sts.out_free) begin
					cmd.out_load_entry = 1'b1;
					if (sts.off_one) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						cmd.dump_rd = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> design/wbfs_dpath.sv
// entry store, pointers, width sum and result register of the shelf
`timescale 1ns / 1ps
`default_nettype none
module wbfs_dpath
	import wbfs_pkg::*;
#(
	parameter int MAX_BOOKS = MAX_BOOKS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic [ID_W-1:0]    in_id,
	input  wire logic [WIDTH_W-1:0] in_width,
	input  wire logic [CAP_W-1:0]   capacity,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [ID_W-1:0]         out_id,
	output logic                    out_empty,
	output logic                    out_last
);

	localparam int IW = (MAX_BOOKS > 1) ? $clog2(MAX_BOOKS) : 1;
	localparam int CW = $clog2(MAX_BOOKS + 1);
	localparam logic [CW:0]   MAX_EXT  = (CW+1)'(MAX_BOOKS);
	localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_BOOKS);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BOOKS - 1);

	entry_t mem [MAX_BOOKS];

	logic [IW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      off_q;
	logic [WIDTH_W-1:0] total_q;
	logic [ID_W-1:0]    item_id_q;
	logic [WIDTH_W-1:0] item_w_q;
	entry_t             rdata_q;
	logic               rv_q;
	logic               out_valid_q;
	logic [ID_W-1:0]    out_id_q;
	logic               out_empty_q;
	logic               out_last_q;

	logic [CW-1:0] rd_off, wr_off;
	logic [CW:0]   rd_sum, wr_sum;
	logic [IW-1:0] rd_addr, wr_addr, head_inc;
	logic          rd_en, wr_en;
	entry_t        wr_data;
	logic [CAP_W:0] fit_sum;
	logic          out_load;

	function automatic logic in_width_gt_cap(input logic [WIDTH_W-1:0] w,
			input logic [CAP_W-1:0] c);
		in_width_gt_cap = (w > c);
	endfunction

	// logical offset from the oldest entry to physical slot
	always_comb begin
		if (cmd.rd_head) begin
			rd_off = '0;
		end else if (cmd.scan_rd) begin
			rd_off = off_q;
		end else if (cmd.dump_init) begin
			rd_off = count_q - CW'(1);
		end else begin
			rd_off = off_q - CW'(2);
		end
		wr_off = cmd.shift_wr ? (off_q - CW'(2)) : count_q;
		rd_sum = {1'b0, CW'(head_q)} + {1'b0, rd_off};
		wr_sum = {1'b0, CW'(head_q)} + {1'b0, wr_off};
		rd_addr = (rd_sum >= MAX_EXT) ? IW'(rd_sum - MAX_EXT) : IW'(rd_sum);
		wr_addr = (wr_sum >= MAX_EXT) ? IW'(wr_sum - MAX_EXT) : IW'(wr_sum);
		head_inc = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
	end

	assign rd_en   = cmd.rd_head | cmd.scan_rd | cmd.dump_init | cmd.dump_rd;
	assign wr_en   = cmd.append | cmd.shift_wr;
	assign wr_data = cmd.shift_wr ? rdata_q : entry_t'{id: item_id_q, width: item_w_q};
	assign fit_sum = {1'b0, total_q} + {1'b0, item_w_q};
	assign out_load = cmd.out_load_entry | cmd.out_load_empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (cmd.load) begin
			item_id_q <= in_id;
			item_w_q  <= in_width;
		end
		if (out_load) begin
			out_id_q    <= cmd.out_load_entry ? rdata_q.id : '0;
			out_empty_q <= cmd.out_load_empty;
			out_last_q  <= cmd.out_load_empty | (off_q == CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			off_q       <= '0;
			total_q     <= '0;
			rv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_q <= rd_en;
			if (cmd.clear) begin
				count_q <= '0;
				total_q <= '0;
			end else if (cmd.evict) begin
				count_q <= count_q - CW'(1);
				total_q <= total_q - rdata_q.width;
				head_q  <= head_inc;
			end else if (cmd.append) begin
				count_q <= count_q + CW'(1);
				total_q <= WIDTH_W'(fit_sum);
			end else if (cmd.rem_sub) begin
				total_q <= total_q - rdata_q.width;
			end else if (cmd.rem_done) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load) begin
				off_q <= '0;
			end else if (cmd.scan_rd) begin
				off_q <= off_q + CW'(1);
			end else if (cmd.dump_init) begin
				off_q <= count_q;
			end else if (cmd.dump_rd) begin
				off_q <= off_q - CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.too_wide   = in_width_gt_cap(item_w_q, capacity);
		sts.need_evict = (count_q != '0)
			&& ((fit_sum > {1'b0, capacity}) || (count_q == MAX_CNT));
		sts.count_zero = (count_q == '0);
		sts.scan_more  = (off_q < count_q);
		sts.rd_valid   = rv_q;
		sts.id_match   = (rdata_q.id == item_id_q);
		sts.off_one    = (off_q == CW'(1));
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_id    = out_id_q;
	assign out_empty = out_empty_q;
	assign out_last  = out_last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("entry count beyond store depth");

	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> count_q != '0)
		else $error("eviction from an empty store");

	a_shift_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift_wr && cmd.scan_rd) |-> wr_addr != rd_addr)
		else $error("gap closing writes the slot being read");

	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");
`endif

endmodule
`default_nettype wire

>>> design/width_bounded_fifo_shelf.sv
// top level of the width bounded fifo shelf: stream ports, apb register, controller and datapath
// sequence: add runs a check state, plus an evict state and another check per evicted entry;
// remove makes one pipelined read per held entry through the single store read port, and the
// gap is closed behind the scan at one entry a cycle; dump: one result a cycle unless stalled
// throughput: one item at a time, the next is taken once the current one has finished
// reset: arst_n clears the controller, count, width sum and result valid flag, and sets the
// capacity to 65535; the store itself is not cleared, the count marks what is held
`timescale 1ns / 1ps
`default_nettype none
module width_bounded_fifo_shelf
	import wbfs_pkg::*;
#(
	parameter int MAX_BOOKS = MAX_BOOKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input item stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // book_id [15:0], book_width [31:16]
	input  wire logic [1:0]  s_axis_tuser,  // mode [1:0]
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // out_id [15:0]
	output logic [0:0]       m_axis_tuser,  // was_empty [0]
	output logic             m_axis_tlast,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic [1:0] ADDR_CAPACITY = 2'd0;

	cmd_t cmd;
	sts_t sts;

	logic [CAP_W-1:0] cap_q;
	logic             cfg_wr;
	logic             res_empty;

	// capacity register, written in the access phase of an apb transfer
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '1;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// reads of any other address return zero
	assign prdata = (paddr == ADDR_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_q} : '0;

	// sequencer: walks each item through add, remove or dump
	wbfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, pointers and result register
	wbfs_dpath #(
		.MAX_BOOKS (MAX_BOOKS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_id     (s_axis_tdata[15:0]),
		.in_width  (s_axis_tdata[31:16]),
		.capacity  (cap_q),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_id    (m_axis_tdata),
		.out_empty (res_empty),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tuser = res_empty;

endmodule
`default_nettype wire
